// ===== rtl/npe_pkg.sv =====
// Shared constants and types for the NAND page ECC encoder.
package npe_pkg;

	localparam int unsigned SYN_W = 26;
	localparam int unsigned POS_W = 10;
	localparam int unsigned BIT_IDX_W = POS_W + 3;

	localparam logic [POS_W-1:0] PAGE_LAST_POS = 10'd527;
	localparam logic [BIT_IDX_W-1:0] DATA_BITS = 13'h1066;
	localparam logic [BIT_IDX_W-1:0] ECC_END_BITS = 13'h1080;
	localparam logic [SYN_W:0] LFSR_POLY = 27'h6954559;

	// Result of processing one page byte
	typedef struct packed {
		logic [7:0] data;
		logic [SYN_W-1:0] syn;
	} npe_step_t;

endpackage

// ===== rtl/npe_byte_step.sv =====
// Eight-bit LFSR step: feeds data bits or inserts ECC bits for one page byte.
module npe_byte_step
	import npe_pkg::*;
(
	input  logic [SYN_W-1:0] syn_in,
	input  logic [POS_W-1:0] pos,
	input  logic [7:0]       data,
	output npe_step_t        step
);

	logic [SYN_W-1:0] syn;
	logic [SYN_W:0] v;
	logic [7:0] res;
	logic [BIT_IDX_W-1:0] bit_idx;

	// Walk the byte least significant bit first
	always_comb begin
		syn = (pos == '0) ? '0 : syn_in;
		res = data;
		v = '0;
		bit_idx = '0;
		for (int b = 0; b < 8; b++) begin
			bit_idx = {pos, 3'(b)};
			if (bit_idx < DATA_BITS) begin
				// shift an inverted data bit through the LFSR
				v = {1'b0, syn} ^ {{SYN_W{1'b0}}, ~data[b]};
				if (v[0]) begin
					v = v ^ LFSR_POLY;
				end
				syn = v[SYN_W:1];
			end else if (bit_idx < ECC_END_BITS) begin
				// emit an inverted parity bit and drain the register
				res[b] = ~syn[0];
				syn = {1'b0, syn[SYN_W-1:1]};
			end
		end
		step.data = res;
		step.syn = syn;
	end

endmodule

// ===== rtl/nand_page_ecc_encoder_core.sv =====
// NAND page ECC encoder top level: input register, byte step, output register.
//
// Streams a 528-byte flash page one byte per transfer and returns it one byte
// per transfer, with 26 parity bits from a 26-bit LFSR written into page bit
// positions 4198..4223 (upper two bits of byte 524, all of bytes 525..527).
// The block takes one byte every clock cycle while the output is not stalled;
// an accepted byte is held in the input register and moves into the output
// register once the output register is empty or being read.
// The rate is set by the syndrome feedback loop, which performs all eight LFSR
// steps of a byte in one syndrome update. page_last marks byte 527; the byte count
// restarts at zero after reset and after every page, and the syndrome clears
// at each page start.
module nand_page_ecc_encoder_core
	import npe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_out,
	output logic       page_last
);

	logic v_s1;
	logic [7:0] data_s1;
	logic [POS_W-1:0] pos_s1;
	logic [POS_W-1:0] pos_q;
	logic [SYN_W-1:0] syn_q;
	logic adv_s1;
	logic in_xfer;
	npe_step_t step;

	assign adv_s1 = v_s1 && (!out_valid || out_ready);
	assign in_ready = !v_s1 || adv_s1;
	assign in_xfer = in_valid && in_ready;

	// Count bytes within the page
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_xfer) begin
			pos_q <= (pos_q == PAGE_LAST_POS) ? '0 : pos_q + POS_W'(1);
		end
	end

	// Hold the accepted byte with its position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			data_s1 <= data_in;
			pos_s1 <= pos_q;
		end
	end

	npe_byte_step u_step (
		.syn_in(syn_q),
		.pos   (pos_s1),
		.data  (data_s1),
		.step  (step)
	);

	// Advance the syndrome as each byte leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			syn_q <= '0;
		end else if (adv_s1) begin
			syn_q <= step.syn;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s1) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			data_out <= step.data;
			page_last <= (pos_s1 == PAGE_LAST_POS);
		end
	end

	// Byte count never leaves the page
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PAGE_LAST_POS)
		else $error("byte position out of page range");

	// Parity bits fully drain the LFSR by the end of a page
	a_syn_drained: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && (pos_s1 == PAGE_LAST_POS) |=> syn_q == '0)
		else $error("syndrome not empty after last page byte");

	// Last byte of the page is flagged at the output
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && (pos_s1 == PAGE_LAST_POS) |=> out_valid && page_last)
		else $error("page_last missing on final byte");

	// Byte count wraps after the final byte
	a_pos_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (pos_q == PAGE_LAST_POS) |=> pos_q == '0)
		else $error("byte position failed to wrap");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the NAND page ECC encoder core.
module tb_top;
	import npe_pkg::*;

	localparam int unsigned RAND_BYTES = 552;
	localparam int unsigned CALM_START = 100;
	localparam int unsigned CALM_END = 300;
	localparam int unsigned RX_HOLD_CYCLES = 80;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned STALL_LIMIT = 1000;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned NUM_ROWS = 8;

	// One directed stimulus row: a byte value, repeated or randomized
	typedef struct packed {
		logic [7:0] data;
		logic [9:0] reps;
		logic rnd;
		logic typed;
		logic [7:0] exp_data;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] data;
		logic last;
	} page_byte_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] data_in;
	logic out_valid;
	logic out_ready;
	logic [7:0] data_out;
	logic page_last;

	// Expectation attached to the byte currently offered
	logic tx_typed;
	logic [7:0] tx_exp;

	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	bit rx_hold_req;
	int unsigned mismatch_cnt;
	int unsigned stall_cycles;

	// Predictor state
	logic [SYN_W-1:0] ecc_lfsr;
	logic [POS_W-1:0] page_pos;
	page_byte_t expected_bytes[$];

	// Leading data bytes of a page pass through untouched
	stim_row_t directed_rows [NUM_ROWS] = '{
		'{8'h00, 10'd1, 1'b0, 1'b1, 8'h00},
		'{8'hFF, 10'd1, 1'b0, 1'b1, 8'hFF},
		'{8'h01, 10'd1, 1'b0, 1'b1, 8'h01},
		'{8'h80, 10'd1, 1'b0, 1'b1, 8'h80},
		'{8'h55, 10'd1, 1'b0, 1'b1, 8'h55},
		'{8'hAA, 10'd1, 1'b0, 1'b1, 8'hAA},
		'{8'h5A, 10'd1, 1'b0, 1'b0, 8'h00},
		'{8'h00, 10'd1, 1'b1, 1'b0, 8'h00}
	};

	nand_page_ecc_encoder_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.data_in  (data_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.data_out (data_out),
		.page_last(page_last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Encode one page byte: feed data bits through the LFSR, then emit inverted ECC bits
	function automatic void encode_byte(input logic [7:0] din, output logic [7:0] dout,
			output logic last);
		logic [BIT_IDX_W-1:0] bit_idx;
		logic [SYN_W:0] fb;
		dout = din;
		if (page_pos == '0) begin
			ecc_lfsr = '0;
		end
		for (int b = 0; b < 8; b++) begin
			bit_idx = {page_pos, 3'(b)};
			if (bit_idx < DATA_BITS) begin
				fb = {1'b0, ecc_lfsr} ^ {{SYN_W{1'b0}}, ~din[b]};
				if (fb[0]) begin
					fb = fb ^ LFSR_POLY;
				end
				ecc_lfsr = fb[SYN_W:1];
			end else if (bit_idx < ECC_END_BITS) begin
				dout[b] = ~ecc_lfsr[0];
				ecc_lfsr = ecc_lfsr >> 1;
			end
		end
		last = (page_pos == PAGE_LAST_POS);
		page_pos = last ? '0 : page_pos + POS_W'(1);
	endfunction

	function automatic void flag_mismatch(input string msg);
		if (mismatch_cnt < MAX_REPORTS) begin
			$display("%0t: mismatch: %s", $time, msg);
		end
		mismatch_cnt++;
	endfunction

	// Bias toward all-zero and all-one bytes now and then
	function automatic logic [7:0] rand_page_byte();
		case ($urandom_range(0, 9))
			0: rand_page_byte = 8'h00;
			1: rand_page_byte = 8'hFF;
			default: rand_page_byte = 8'($urandom);
		endcase
	endfunction

	// Offer one byte after a random gap and hold it until the transfer
	task automatic send_byte(input logic [7:0] b, input logic typed, input logic [7:0] exp_b);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_in <= b;
		tx_typed <= typed;
		tx_exp <= exp_b;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Drive out_ready at random, with one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				out_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 1'b0;
			end
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Predict on each input transfer, check each output transfer, watch for hangs
	always @(posedge clk) begin : scoreboard
		page_byte_t want;
		logic [7:0] pred_data;
		logic pred_last;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				encode_byte(data_in, pred_data, pred_last);
				want.data = tx_typed ? tx_exp : pred_data;
				want.last = pred_last;
				expected_bytes.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					flag_mismatch($sformatf("unexpected byte %h last %b", data_out, page_last));
				end else begin
					want = expected_bytes.pop_front();
					if (data_out !== want.data) begin
						flag_mismatch($sformatf("data_out exp %h got %h", want.data, data_out));
					end
					if (page_last !== want.last) begin
						flag_mismatch($sformatf("page_last exp %b got %b", want.last, page_last));
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("tb_top: FAIL");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_in = 8'h00;
		tx_typed = 1'b0;
		tx_exp = 8'h00;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_req = 1'b0;
		mismatch_cnt = 0;
		stall_cycles = 0;
		ecc_lfsr = '0;
		page_pos = '0;

		// Hold reset, then release away from the rising edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the directed table
		tx_idle_pct = 24;
		rx_idle_pct = 24;
		for (int r = 0; r < NUM_ROWS; r++) begin
			for (int n = 0; n < directed_rows[r].reps; n++) begin
				send_byte(directed_rows[r].rnd ? rand_page_byte() : directed_rows[r].data,
					directed_rows[r].typed, directed_rows[r].exp_data);
			end
		end

		// Pause the sender until every pending byte has come out
		in_valid <= 1'b0;
		while (expected_bytes.size() != 0) begin
			@(negedge clk);
		end

		// Random bytes through the page tail and into the next page;
		// stall the output early so the input backs up, then run a stretch with no idling
		rx_hold_req = 1'b1;
		for (int n = 0; n < RAND_BYTES; n++) begin
			tx_idle_pct = (n >= CALM_START && n < CALM_END) ? 0 : 24;
			rx_idle_pct = (n >= CALM_START && n < CALM_END) ? 0 : 24;
			send_byte(rand_page_byte(), 1'b0, 8'h00);
		end
		in_valid <= 1'b0;

		// Drain the pipeline
		while (expected_bytes.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_bytes.size() != 0) begin
			flag_mismatch($sformatf("%0d bytes never came out", expected_bytes.size()));
		end

		if (mismatch_cnt == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
